// ===== sv/nrml_pkg.sv =====
package nrml_pkg;

   // defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int FREQ_BITS_DEF   = 27;

   // fixed field widths of the channel words
   localparam int FIELD_BITS = 27;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 7;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 27;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPAN_LIMIT  = 1'b1;

   localparam logic [FIELD_BITS-1:0] SPAN_LIMIT_RESET = 27'd134000000;

   // item modes
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [INDEX_BITS-1:0] entry_index;
      logic [FIELD_BITS-1:0] range_low;
      logic [FIELD_BITS-1:0] range_high;
      logic [FIELD_BITS-1:0] frequency;
   } req_word_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] match_index;
   } rsp_word_type;

   // one table read travelling down the compare pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_beat_type;

   // state of the running best match
   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

// ===== sv/narrowest_range_match_lookup_unit.sv =====
// Write word: taken while idle, gives no response; the next word may follow at once.
// Lookup word: one table entry read per cycle from the read port of the range memory;
//   the next word is taken once the response has been issued.
// Lookup with an empty table scan: no table read; the sequencer answers with a miss.
// Reset (synchronous): entry_count 0, span_limit 134000000, pipeline idle, no response
//   pending; the range memory is not cleared and must be loaded before it is scanned.
module narrowest_range_match_lookup_unit import nrml_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FREQ_BITS   = FREQ_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   // configuration writes
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int WIDE_BITS = 32;
   localparam logic [WIDE_BITS-1:0] LIMIT_WIDE = WIDE_BITS'(SPAN_LIMIT_RESET);
   localparam logic [FREQ_BITS-1:0] LIMIT_RST  = LIMIT_WIDE[FREQ_BITS-1:0];

   typedef enum logic [1:0] {
      ST_IDLE,   // waiting for a word
      ST_SCAN,   // issuing one table read per cycle
      ST_WAIT,   // compare pipeline draining
      ST_POST    // result ready, waiting for the response slot
   } state_type;

   // ---------------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------------
   logic [COUNT_BITS-1:0] entry_count_ff, entry_count_in;
   logic [FREQ_BITS-1:0]  span_limit_ff, span_limit_in;
   logic [WIDE_BITS-1:0]  csr_wide;

   always_comb begin
      csr_wide       = WIDE_BITS'(csr_wdata);
      entry_count_in = entry_count_ff;
      span_limit_in  = span_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: entry_count_in = csr_wdata[COUNT_BITS-1:0];
            CSR_SPAN_LIMIT:  span_limit_in  = csr_wide[FREQ_BITS-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         span_limit_ff  <= LIMIT_RST;
      end else begin
         entry_count_ff <= entry_count_in;
         span_limit_ff  <= span_limit_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request decode; bounds are cut or zero-extended to the internal width
   // ---------------------------------------------------------------------------------------
   logic                 req_take;
   logic [WIDE_BITS-1:0] low_wide, high_wide, freq_wide;
   logic [FREQ_BITS-1:0] req_low, req_high, req_freq;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [8:0]           scan_count;   // entries to scan, clipped to the table depth

   always_comb begin
      req_take  = req_valid && !req_stall;
      low_wide  = WIDE_BITS'(req_word.range_low);
      high_wide = WIDE_BITS'(req_word.range_high);
      freq_wide = WIDE_BITS'(req_word.frequency);
      req_low   = low_wide[FREQ_BITS-1:0];
      req_high  = high_wide[FREQ_BITS-1:0];
      req_freq  = freq_wide[FREQ_BITS-1:0];
      // a slot beyond the depth is dropped
      wr_en     = req_take && (req_word.mode == MODE_WRITE) &&
                  (WIDE_BITS'(req_word.entry_index) < WIDE_BITS'(TABLE_DEPTH));
      wr_addr   = ADDR_BITS'(req_word.entry_index);
      if (WIDE_BITS'(entry_count_ff) > WIDE_BITS'(TABLE_DEPTH)) begin
         scan_count = 9'(TABLE_DEPTH);
      end else begin
         scan_count = 9'(entry_count_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Range memory: low and high bound side by side, one write and one registered read port.
   // Writes only land while idle, so a scan never overlaps a write to the same entry.
   // ---------------------------------------------------------------------------------------
   logic [2*FREQ_BITS-1:0] range_mem [TABLE_DEPTH];
   logic [2*FREQ_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]   scan_idx_ff, scan_idx_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[wr_addr] <= {req_low, req_high};
      end
      rd_data_ff <= range_mem[scan_idx_ff];
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] last_idx_ff, last_idx_in;
   logic [FREQ_BITS-1:0] freq_ff, freq_in;
   logic                 empty_ff, empty_in;
   scan_beat_type        beat_ff, beat_in;
   logic [ADDR_BITS-1:0] beat_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                 rsp_free;

   scan_status_type      status;
   logic [ADDR_BITS-1:0] best_idx;

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      last_idx_in  = last_idx_ff;
      freq_in      = freq_ff;
      empty_in     = empty_ff;
      beat_in      = '0;
      rsp_word_in  = rsp_word_ff;
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_word.mode == MODE_LOOKUP)) begin
               freq_in     = req_freq;
               scan_idx_in = '0;
               last_idx_in = ADDR_BITS'(scan_count - 9'd1);
               if (scan_count == 9'd0) begin
                  empty_in = 1'b1;
                  state_in = ST_POST;
               end else begin
                  empty_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            beat_in.valid = 1'b1;
            beat_in.first = (scan_idx_ff == '0);
            beat_in.last  = (scan_idx_ff == last_idx_ff);
            if (scan_idx_ff == last_idx_ff) begin
               state_in = ST_WAIT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (status.done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (!empty_ff && status.found) begin
                  rsp_word_in.found       = 1'b1;
                  rsp_word_in.match_index = INDEX_BITS'(best_idx);
               end else begin
                  rsp_word_in.found       = 1'b0;
                  rsp_word_in.match_index = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_idx_ff <= last_idx_in;
      freq_ff     <= freq_in;
      empty_ff    <= empty_in;
      beat_idx_ff <= scan_idx_ff;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------------------------
   // Compare pipeline: containment and span, then the running narrowest match
   // ---------------------------------------------------------------------------------------
   nrml_best #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FREQ_BITS   (FREQ_BITS)
   ) u_best (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat_ff),
      .beat_idx   (beat_idx_ff),
      .rd_low     (rd_data_ff[2*FREQ_BITS-1:FREQ_BITS]),
      .rd_high    (rd_data_ff[FREQ_BITS-1:0]),
      .freq       (freq_ff),
      .span_limit (span_limit_ff),
      .status     (status),
      .best_idx   (best_idx)
   );

   // ---------------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------------
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == ST_WAIT))
      else $error("scan finished outside the wait state");

   a_beat_from_scan: assert property (@(posedge clock) disable iff (reset)
      beat_ff.valid |-> $past(state_ff == ST_SCAN))
      else $error("table read beat without a scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= last_idx_ff))
      else $error("scan address past the last entry");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.found) |-> (rsp_word.match_index == '0))
      else $error("miss response carries a non-zero index");

endmodule

// ===== sv/nrml_best.sv =====
module nrml_best import nrml_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FREQ_BITS   = FREQ_BITS_DEF,
   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_beat_type        beat,
   input  logic [ADDR_BITS-1:0] beat_idx,
   input  logic [FREQ_BITS-1:0] rd_low,
   input  logic [FREQ_BITS-1:0] rd_high,
   input  logic [FREQ_BITS-1:0] freq,
   input  logic [FREQ_BITS-1:0] span_limit,
   output scan_status_type      status,
   output logic [ADDR_BITS-1:0] best_idx
);

   // stage A: containment and span
   scan_beat_type        a_beat_ff;
   logic [ADDR_BITS-1:0] a_idx_ff;
   logic                 a_hit_ff;
   logic [FREQ_BITS-1:0] a_span_ff;
   logic                 a_hit_in;
   logic [FREQ_BITS-1:0] a_span_in;

   // stage B: running best
   logic [FREQ_BITS-1:0] best_span_ff, best_span_in;
   logic [ADDR_BITS-1:0] best_idx_ff, best_idx_in;
   logic                 found_ff, found_in;
   logic                 done_ff, done_in;
   logic [FREQ_BITS-1:0] bound;
   logic                 take;

   always_comb begin
      a_hit_in  = (freq >= rd_low) && (freq <= rd_high);
      a_span_in = rd_high - rd_low;
   end

   always_comb begin
      bound = a_beat_ff.first ? span_limit : best_span_ff;
      // strict compare keeps the lowest index on a tie
      take  = a_beat_ff.valid && a_hit_ff && (a_span_ff < bound);

      best_span_in = best_span_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      if (a_beat_ff.valid) begin
         best_span_in = take ? a_span_ff : bound;
         if (take) begin
            best_idx_in = a_idx_ff;
            found_in    = 1'b1;
         end else if (a_beat_ff.first) begin
            best_idx_in = '0;
            found_in    = 1'b0;
         end
      end
      done_in = a_beat_ff.valid && a_beat_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_beat_ff <= '0;
         found_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         a_beat_ff <= beat;
         found_ff  <= found_in;
         done_ff   <= done_in;
      end
      a_idx_ff     <= beat_idx;
      a_hit_ff     <= a_hit_in;
      a_span_ff    <= a_span_in;
      best_span_ff <= best_span_in;
      best_idx_ff  <= best_idx_in;
   end

   assign status.done  = done_ff;
   assign status.found = found_ff;
   assign best_idx     = best_idx_ff;

endmodule

// ===== tb/sv/nrml_lookup_checker.sv =====
module nrml_lookup_checker import nrml_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_word_type              req_word,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_word_type              rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        error_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = TABLE_DEPTH_DEF;

   logic [COUNT_BITS-1:0] scan_count;
   logic [FIELD_BITS-1:0] span_cap;
   logic [FIELD_BITS-1:0] low_copy [DEPTH];
   logic [FIELD_BITS-1:0] high_copy [DEPTH];
   rsp_word_type          expected_matches [$];

   // narrowest containing range below the span cap; a later entry must be
   // strictly narrower, so the lowest index keeps a tie
   function automatic rsp_word_type narrowest_match(input logic [FIELD_BITS-1:0] freq);
      rsp_word_type          hit;
      logic [FIELD_BITS-1:0] best_span;
      logic [FIELD_BITS-1:0] span;
      int                    limit;
      int                    i;
      hit       = '0;
      best_span = span_cap;
      limit     = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
      for (i = 0; i < limit; i++) begin
         if (freq >= low_copy[i] && freq <= high_copy[i]) begin
            span = high_copy[i] - low_copy[i];
            if (span < best_span) begin
               best_span       = span;
               hit.found       = 1'b1;
               hit.match_index = i[INDEX_BITS-1:0];
            end
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      int           fails;
      fails = 0;
      if (reset) begin
         scan_count = '0;
         span_cap   = SPAN_LIMIT_RESET;
         expected_matches.delete();
         error_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ENTRY_COUNT) begin
               scan_count = csr_wdata[COUNT_BITS-1:0];
            end else if (csr_index == CSR_SPAN_LIMIT) begin
               span_cap = csr_wdata[FIELD_BITS-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            if (req_word.mode == MODE_WRITE) begin
               low_copy[req_word.entry_index]  = req_word.range_low;
               high_copy[req_word.entry_index] = req_word.range_high;
            end else begin
               expected_matches.push_back(narrowest_match(req_word.frequency));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: unexpected response word found=%0b index=%0d",
                        $time, rsp_word.found, rsp_word.match_index);
               fails++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_word.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, rsp_word.found);
                  fails++;
               end
               if (rsp_word.match_index !== want.match_index) begin
                  $display("%0t: match_index mismatch, expected %0d, got %0d",
                           $time, want.match_index, rsp_word.match_index);
                  fails++;
               end
            end
         end
         error_count <= error_count + fails;
      end
      pending_count <= expected_matches.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nrml_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          LATENCY_CYCLES  = 72;    // full scan of 64 entries plus pipeline
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          PHASES          = 14;
   localparam int          PHASE_WORDS     = 105;
   localparam int          TABLE_SLOTS     = TABLE_DEPTH_DEF;
   localparam logic [FIELD_BITS-1:0] FREQ_TOP = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_word_type              req_word;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_word_type              rsp_word;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int          error_count;
   int          pending_count;
   int unsigned cycle_count = 0;

   // idle odds: one gap in N words, 0 means none
   int idle_one_in  = 0;
   int stall_one_in = 0;
   bit hold_off_request = 1'b0;

   // bounds as written, so lookups can be aimed at edges and nested ranges
   logic [FIELD_BITS-1:0] aim_low  [TABLE_SLOTS];
   logic [FIELD_BITS-1:0] aim_high [TABLE_SLOTS];
   // most ranges crowd into one band so that they overlap and nest
   logic [FIELD_BITS-1:0] band_base;

   narrowest_range_match_lookup_unit u_dut (.*);

   nrml_lookup_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // --- response side: short random stalls, plus one long hold-off on request
   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_request && !held_off) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_one_in != 0 && $urandom_range(1, stall_one_in) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // --- word builders
   function automatic req_word_type write_word(input logic [INDEX_BITS-1:0] slot,
                                               input logic [FIELD_BITS-1:0] lo,
                                               input logic [FIELD_BITS-1:0] hi);
      req_word_type w;
      w.mode        = MODE_WRITE;
      w.entry_index = slot;
      w.range_low   = lo;
      w.range_high  = hi;
      w.frequency   = FIELD_BITS'($urandom);   // ignored on a write
      return w;
   endfunction

   function automatic req_word_type lookup_word(input logic [FIELD_BITS-1:0] freq);
      req_word_type w;
      w.mode        = MODE_LOOKUP;
      w.entry_index = INDEX_BITS'($urandom);   // the rest is ignored on a lookup
      w.range_low   = FIELD_BITS'($urandom);
      w.range_high  = FIELD_BITS'($urandom);
      w.frequency   = freq;
      return w;
   endfunction

   // random table entry: mostly short ranges in the band, with inverted,
   // full-width, point, duplicate (tie) and wide covering ranges mixed in
   function automatic req_word_type random_entry(input logic [INDEX_BITS-1:0] slot);
      logic [FIELD_BITS-1:0] lo;
      logic [FIELD_BITS-1:0] hi;
      int unsigned           k;
      k = $urandom_range(0, TABLE_SLOTS - 1);
      case ($urandom_range(0, 19))
         0: begin
            lo = FIELD_BITS'($urandom_range(1, FREQ_TOP));
            hi = FIELD_BITS'($urandom_range(0, lo - 1));
         end
         1: begin
            lo = '0;
            hi = FREQ_TOP;
         end
         2: begin
            lo = $urandom_range(0, 1) ? FREQ_TOP : '0;
            hi = lo;
         end
         3: begin
            lo = FIELD_BITS'($urandom);
            hi = FIELD_BITS'($urandom);
         end
         4, 5: begin
            lo = aim_low[k];
            hi = aim_high[k];
         end
         6: begin
            lo = FIELD_BITS'($urandom_range(0, band_base));
            hi = band_base + FIELD_BITS'(8192) + FIELD_BITS'($urandom_range(0, 1 << 20));
         end
         default: begin
            lo = band_base + FIELD_BITS'($urandom_range(0, 4095));
            hi = lo + FIELD_BITS'($urandom_range(0, 2047));
         end
      endcase
      return write_word(slot, lo, hi);
   endfunction

   // lookup frequency: bounds and just outside them, inside a range, in the band,
   // anywhere, or the extremes
   function automatic logic [FIELD_BITS-1:0] aimed_frequency();
      int unsigned           j;
      logic [FIELD_BITS-1:0] f;
      j = $urandom_range(0, TABLE_SLOTS - 1);
      case ($urandom_range(0, 9))
         0: f = aim_low[j];
         1: f = aim_high[j];
         2: f = aim_low[j] - FIELD_BITS'(1);
         3: f = aim_high[j] + FIELD_BITS'(1);
         4, 5, 6: begin
            if (aim_low[j] <= aim_high[j]) begin
               f = aim_low[j] + FIELD_BITS'($urandom_range(0, aim_high[j] - aim_low[j]));
            end else begin
               f = aim_low[j];
            end
         end
         7: f = band_base + FIELD_BITS'($urandom_range(0, 6143));
         8: f = FIELD_BITS'($urandom);
         default: f = $urandom_range(0, 1) ? FREQ_TOP : '0;
      endcase
      return f;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_for(input int p);
      case (p)
         0, 3, 8, 11, 13: return 7'd64;
         1:               return 7'd1;
         2:               return 7'd127;   // beyond depth: scans all 64
         4:               return 7'd0;
         5:               return 7'd65;
         7:               return 7'd63;
         9:               return 7'd2;
         10:              return 7'd100;
         default:         return COUNT_BITS'($urandom_range(3, 62));
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] limit_for(input int p);
      case (p % 7)
         0, 3:    return SPAN_LIMIT_RESET;
         1:       return FREQ_TOP;
         2:       return FIELD_BITS'($urandom_range(1, 2048));
         4:       return FIELD_BITS'(1);
         5:       return FIELD_BITS'($urandom);
         default: return FIELD_BITS'($urandom_range(0, 4));
      endcase
   endfunction

   // --- request side
   // offer one word and hold it until taken; returns just after the accepting edge
   task automatic push_word(input req_word_type w);
      if (idle_one_in != 0 && $urandom_range(1, idle_one_in) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.mode == MODE_WRITE) begin
         aim_low[w.entry_index]  = w.range_low;
         aim_high[w.entry_index] = w.range_high;
      end
   endtask

   // stop offering and let every lookup come back, then allow for a trailing scan
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic [COUNT_BITS-1:0] count,
                             input logic [FIELD_BITS-1:0] limit);
      drain();
      write_csr(CSR_ENTRY_COUNT, CSR_DATA_BITS'(count));
      write_csr(CSR_SPAN_LIMIT, CSR_DATA_BITS'(limit));
   endtask

   initial begin
      int p;
      int k;
      int slot;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_ENTRY_COUNT;
      csr_wdata <= '0;
      for (slot = 0; slot < TABLE_SLOTS; slot++) begin
         aim_low[slot]  = '0;
         aim_high[slot] = '0;
      end
      band_base = FIELD_BITS'($urandom_range(0, FREQ_TOP - (1 << 22)));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty scan straight out of reset (count resets to 0)
      push_word(lookup_word('0));
      push_word(lookup_word(FREQ_TOP));

      // small hand-built table
      push_word(write_word(6'd0, 27'd100, 27'd200));
      push_word(write_word(6'd1, 27'd150, 27'd180));    // narrower, nested in 0
      push_word(write_word(6'd2, 27'd150, 27'd180));    // same span as 1: lower index wins
      push_word(write_word(6'd3, 27'd500, 27'd400));    // inverted, never matches
      push_word(write_word(6'd4, '0, '0));
      push_word(write_word(6'd5, FREQ_TOP, FREQ_TOP));
      push_word(write_word(6'd6, '0, FREQ_TOP));        // span above the reset limit
      push_word(write_word(6'd7, 27'd1000, 27'd2000));
      set_config(7'd8, SPAN_LIMIT_RESET);
      push_word(lookup_word(27'd160));
      push_word(lookup_word(27'd100));
      push_word(lookup_word(27'd200));
      push_word(lookup_word(27'd201));
      push_word(lookup_word('0));
      push_word(lookup_word(FREQ_TOP));
      push_word(lookup_word(27'd450));
      push_word(lookup_word(27'd1500));
      push_word(lookup_word(27'd99));

      // span equal to the limit is not enough
      set_config(7'd8, FREQ_TOP);
      push_word(lookup_word(27'd3000));
      push_word(lookup_word(27'd150));
      // limit of zero shuts everything out, limit of one lets only points in
      set_config(7'd8, '0);
      push_word(lookup_word('0));
      set_config(7'd8, 27'd1);
      push_word(lookup_word('0));
      push_word(lookup_word(27'd160));

      // --- random: fill every slot before any wider scan
      idle_one_in  = 6;
      stall_one_in = 6;
      for (slot = 0; slot < TABLE_SLOTS; slot++) begin
         push_word(random_entry(INDEX_BITS'(slot)));
      end

      for (p = 0; p < PHASES; p++) begin
         if (p >= PHASES - 2 || p % 4 == 2) begin
            // quiet stretches, and the tail of the run without gaps at all
            idle_one_in  = 0;
            stall_one_in = 0;
         end else begin
            idle_one_in  = $urandom_range(2, 8);
            stall_one_in = $urandom_range(2, 8);
         end
         set_config(count_for(p), limit_for(p));
         // long receiver hold-off while words keep coming: input must back up
         if (p == 3) hold_off_request = 1'b1;
         for (k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               push_word(random_entry(INDEX_BITS'($urandom_range(0, TABLE_SLOTS - 1))));
            end else begin
               push_word(lookup_word(aimed_frequency()));
            end
         end
      end

      drain();
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
